@@ hdl/gvs_pkg.sv @@
// grain voice sample package: shared types, codes, widths and cosine series constants
// no dependencies; used by every module of the grain voice

package gvs_pkg;

    // default sizes, handed down through top-level parameters
    localparam int AUDIO_DEPTH_DEF = 65536;
    localparam int ENV_DEPTH_DEF   = 1024;
    localparam int COS_DEPTH_DEF   = 256;

    // fixed widths set by the field widths
    localparam int MAG_BITS = 36;   // magnitude of start + floor(position)
    localparam int QUO_BITS = 11;   // envelope index quotient
    localparam int NUM_BITS = 35;   // envelope dividend dt * (len - 1)

    // q30 constants for the cosine series
    localparam longint Q30_ONE     = 64'sd1073741824;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    // item commands
    typedef enum logic [1:0] {
        CMD_PROC     = 2'd0,
        CMD_WR_AUDIO = 2'd1,
        CMD_WR_ENV   = 2'd2
    } t_cmd;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_START    = 3'd0,
        REG_DURATION = 3'd1,
        REG_RATE     = 3'd2,
        REG_PAN      = 3'd3,
        REG_BUF_LEN  = 3'd4,
        REG_ENV_LEN  = 3'd5,
        REG_TRIGGER  = 3'd6
    } t_reg_idx;

    // control traveling with every pipeline stage
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_ctl;

    // configuration after range correction
    typedef struct packed {
        logic [15:0]        start;
        logic [23:0]        dur;    // never zero
        logic signed [15:0] rate;
        logic signed [15:0] pan;
        logic [16:0]        n;      // wrap modulus, 1..depth
        logic [10:0]        len;    // envelope entries, 0..depth
        logic [31:0]        trig;
    } t_cfg;

endpackage

@@ hdl/gvs_if.sv @@
// grain voice sample channel interfaces: input items, result items, register writes
// depends on nothing; payload widths follow the item fields

interface gvs_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic [31:0]        sample_time;
    logic [15:0]        channel_position;
    logic [15:0]        envelope_gain;
    logic [15:0]        write_address;
    logic signed [15:0] write_value;

    modport source (
        output valid, command, sample_time, channel_position, envelope_gain,
        output write_address, write_value,
        input  ready
    );
    modport sink (
        input  valid, command, sample_time, channel_position, envelope_gain,
        input  write_address, write_value,
        output ready
    );
endinterface

interface gvs_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_out;

    modport source (output valid, sample_out, input ready);
    modport sink (input valid, sample_out, output ready);
endinterface

interface gvs_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  reg_index;
    logic [31:0] wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink (input valid, reg_index, wdata, output ready);
endinterface

@@ hdl/gvs_front.sv @@
// grain voice front end: read position, wrap modulo, envelope index and pan index
// depends on gvs_pkg; one remainder bit per pipeline stage, one quotient bit per stage until the quotient is full

module gvs_front #(
    parameter int AUDIO_DEPTH     = gvs_pkg::AUDIO_DEPTH_DEF,
    parameter int ENV_DEPTH       = gvs_pkg::ENV_DEPTH_DEF,
    parameter int COS_TABLE_DEPTH = gvs_pkg::COS_DEPTH_DEF,
    localparam int AAW = (AUDIO_DEPTH > 1) ? $clog2(AUDIO_DEPTH) : 1,
    localparam int EAW = (ENV_DEPTH > 1) ? $clog2(ENV_DEPTH) : 1,
    localparam int CIW = $clog2(COS_TABLE_DEPTH + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  gvs_pkg::t_cfg      i_cfg,
    input  gvs_pkg::t_ctl      i_ctl,
    input  logic [31:0]        i_time,
    input  logic [15:0]        i_chan,
    input  logic [15:0]        i_gain,
    input  logic [15:0]        i_waddr,
    input  logic signed [15:0] i_wval,
    output gvs_pkg::t_ctl      o_ctl,
    output logic [AAW-1:0]     o_a0,
    output logic [AAW-1:0]     o_a1,
    output logic [11:0]        o_frac,
    output logic [CIW-1:0]     o_cidx,
    output logic [15:0]        o_gain,
    output logic [15:0]        o_waddr,
    output logic signed [15:0] o_wval,
    output logic [EAW-1:0]     o_eidx,
    output logic               o_ezero
);

    localparam int MB = gvs_pkg::MAG_BITS;
    localparam int QB = gvs_pkg::QUO_BITS;
    localparam int NB = gvs_pkg::NUM_BITS;
    localparam int PW = 17 + CIW;

    typedef struct packed {
        gvs_pkg::t_ctl      ctl;
        logic [11:0]        frac;
        logic [CIW-1:0]     cidx;
        logic [15:0]        gain;
        logic [15:0]        waddr;
        logic signed [15:0] wval;
        logic               neg;
        logic [MB-1:0]      rem;
        logic [NB-1:0]      erem;
        logic [QB-1:0]      q;
        logic               useq;
        logic [QB-1:0]      efix;
        logic               ezero;
    } t_mst;

    // stage 1: time difference and pan index
    gvs_pkg::t_ctl      r1_ctl;
    logic signed [31:0] r1_dt;
    logic [CIW-1:0]     r1_cidx;
    logic [15:0]        r1_gain;
    logic [15:0]        r1_waddr;
    logic signed [15:0] r1_wval;

    logic [16:0]    w_ph;
    logic [16:0]    w_pt;
    logic [PW-1:0]  w_pprod;

    always_comb begin
        w_ph    = {1'b0, $unsigned(i_cfg.pan) ^ 16'h8000} + {1'b0, i_chan};
        w_pt    = w_ph[16] ? (17'h10000 - {1'b0, w_ph[15:0]}) : {1'b0, w_ph[15:0]};
        w_pprod = PW'(w_pt) * PW'(COS_TABLE_DEPTH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r1_ctl   <= i_ctl;
            r1_dt    <= $signed(i_time - i_cfg.trig);
            r1_cidx  <= w_pprod[16 +: CIW];
            r1_gain  <= i_gain;
            r1_waddr <= i_waddr;
            r1_wval  <= i_wval;
        end
    end

    // stage 2: position product and envelope dividend
    gvs_pkg::t_ctl      r2_ctl;
    logic signed [47:0] r2_p;
    logic [NB-1:0]      r2_num;
    logic               r2_useq;
    logic [QB-1:0]      r2_efix;
    logic               r2_ezero;
    logic [CIW-1:0]     r2_cidx;
    logic [15:0]        r2_gain;
    logic [15:0]        r2_waddr;
    logic signed [15:0] r2_wval;

    logic [10:0] w_lm1;
    logic        n2_useq;
    logic [10:0] n2_efix;

    always_comb begin
        w_lm1 = i_cfg.len - 11'd1;
        if (r1_dt <= 32'sd0) begin
            n2_useq = 1'b0;
            n2_efix = '0;
        end else if ($unsigned(r1_dt) >= {8'b0, i_cfg.dur}) begin
            n2_useq = 1'b0;
            n2_efix = w_lm1;
        end else begin
            n2_useq = 1'b1;
            n2_efix = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r2_ctl   <= r1_ctl;
            r2_p     <= 48'(r1_dt) * 48'($signed(i_cfg.rate));
            r2_num   <= NB'(r1_dt[23:0]) * NB'(w_lm1);
            r2_useq  <= n2_useq;
            r2_efix  <= n2_efix;
            r2_ezero <= (i_cfg.len == 11'd0);
            r2_cidx  <= r1_cidx;
            r2_gain  <= r1_gain;
            r2_waddr <= r1_waddr;
            r2_wval  <= r1_wval;
        end
    end

    // stage 3 onward: signed offset, then restoring remainder and quotient steps
    t_mst r_st [MB+1];
    t_mst n_st [MB+1];

    logic signed [36:0] w_v;
    logic signed [36:0] w_nv;
    logic [MB+16:0]     w_sh;
    logic [NB-1:0]      w_esh;
    int                 k;
    int                 ek;

    always_comb begin
        w_v  = $signed({21'b0, i_cfg.start}) + 37'($signed(r2_p[47:12]));
        w_nv = -w_v;
        w_sh  = '0;
        w_esh = '0;
        k  = 0;
        ek = 0;

        n_st[0].ctl   = r2_ctl;
        n_st[0].frac  = r2_p[11:0];
        n_st[0].cidx  = r2_cidx;
        n_st[0].gain  = r2_gain;
        n_st[0].waddr = r2_waddr;
        n_st[0].wval  = r2_wval;
        n_st[0].neg   = w_v[36];
        n_st[0].rem   = w_v[36] ? w_nv[MB-1:0] : w_v[MB-1:0];
        n_st[0].erem  = r2_num;
        n_st[0].q     = '0;
        n_st[0].useq  = r2_useq;
        n_st[0].efix  = r2_efix;
        n_st[0].ezero = r2_ezero;

        for (int j = 0; j < MB; j++) begin
            n_st[j+1] = r_st[j];
            k    = MB - 1 - j;
            w_sh = (MB+17)'(i_cfg.n) << k;
            if ({17'b0, r_st[j].rem} >= w_sh) begin
                n_st[j+1].rem = r_st[j].rem - w_sh[MB-1:0];
            end
            if (j < QB) begin
                ek    = QB - 1 - j;
                w_esh = NB'(i_cfg.dur) << ek;
                if (r_st[j].erem >= w_esh) begin
                    n_st[j+1].erem = r_st[j].erem - w_esh;
                    n_st[j+1].q    = r_st[j].q | (QB'(1) << ek);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= MB; j++) begin
                r_st[j].ctl.valid <= 1'b0;
            end
        end else if (i_en) begin
            r_st <= n_st;
        end
    end

    // last stage: fold negative offsets and pick the envelope index
    logic [16:0] w_r;
    logic [16:0] w_a0;
    logic [16:0] w_a1;

    always_comb begin
        w_r  = r_st[MB].rem[16:0];
        w_a0 = (r_st[MB].neg && w_r != 17'd0) ? (i_cfg.n - w_r) : w_r;
        w_a1 = (w_a0 == i_cfg.n - 17'd1) ? 17'd0 : (w_a0 + 17'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl.valid <= 1'b0;
        end else if (i_en) begin
            o_ctl   <= r_st[MB].ctl;
            o_a0    <= AAW'(w_a0);
            o_a1    <= AAW'(w_a1);
            o_frac  <= r_st[MB].frac;
            o_cidx  <= r_st[MB].cidx;
            o_gain  <= r_st[MB].gain;
            o_waddr <= r_st[MB].waddr;
            o_wval  <= r_st[MB].wval;
            o_eidx  <= EAW'(r_st[MB].useq ? r_st[MB].q : r_st[MB].efix);
            o_ezero <= r_st[MB].ezero;
        end
    end

endmodule

@@ hdl/gvs_mem.sv @@
// grain voice memories: audio store with two read ports, envelope store, cosine table
// depends on gvs_pkg; writes and reads happen in one stage so item order is kept

module gvs_mem #(
    parameter int AUDIO_DEPTH     = gvs_pkg::AUDIO_DEPTH_DEF,
    parameter int ENV_DEPTH       = gvs_pkg::ENV_DEPTH_DEF,
    parameter int COS_TABLE_DEPTH = gvs_pkg::COS_DEPTH_DEF,
    localparam int AAW = (AUDIO_DEPTH > 1) ? $clog2(AUDIO_DEPTH) : 1,
    localparam int EAW = (ENV_DEPTH > 1) ? $clog2(ENV_DEPTH) : 1,
    localparam int CIW = $clog2(COS_TABLE_DEPTH + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  gvs_pkg::t_ctl      i_ctl,
    input  logic [AAW-1:0]     i_a0,
    input  logic [AAW-1:0]     i_a1,
    input  logic [11:0]        i_frac,
    input  logic [CIW-1:0]     i_cidx,
    input  logic [15:0]        i_gain,
    input  logic [15:0]        i_waddr,
    input  logic signed [15:0] i_wval,
    input  logic [EAW-1:0]     i_eidx,
    input  logic               i_ezero,
    output gvs_pkg::t_ctl      o_ctl,
    output logic signed [15:0] o_m0,
    output logic signed [15:0] o_m1,
    output logic [11:0]        o_frac,
    output logic signed [15:0] o_env,
    output logic               o_ezero,
    output logic [15:0]        o_gain,
    output logic [15:0]        o_pg
);

    logic signed [15:0] r_audio [AUDIO_DEPTH];
    logic signed [15:0] r_envm  [ENV_DEPTH];
    logic [15:0]        w_cos   [COS_TABLE_DEPTH + 1];

    // quarter-wave cosine table, built at elaboration: 9-term horner series in q30
    for (genvar g = 0; g <= COS_TABLE_DEPTH; g++) begin : g_cos
        localparam longint ONE = gvs_pkg::Q30_ONE;
        localparam longint Y   = gvs_pkg::HALF_PI_Q30 * g / COS_TABLE_DEPTH;
        localparam longint Y2  = Y * Y / ONE;
        localparam longint C8  = ONE - (Y2 * ONE / ONE) / 64'sd240;
        localparam longint C7  = ONE - (Y2 * C8 / ONE) / 64'sd182;
        localparam longint C6  = ONE - (Y2 * C7 / ONE) / 64'sd132;
        localparam longint C5  = ONE - (Y2 * C6 / ONE) / 64'sd90;
        localparam longint C4  = ONE - (Y2 * C5 / ONE) / 64'sd56;
        localparam longint C3  = ONE - (Y2 * C4 / ONE) / 64'sd30;
        localparam longint C2  = ONE - (Y2 * C3 / ONE) / 64'sd12;
        localparam longint C1  = ONE - (Y2 * C2 / ONE) / 64'sd2;
        localparam longint QR  = (C1 < 64'sd0) ? 64'sd0 : ((C1 + 64'sd16384) >>> 15);
        localparam logic [15:0] QC = (QR > 64'sd32768) ? 16'h8000 : 16'(QR);
        assign w_cos[g] = QC;
    end

    logic w_wr_audio;
    logic w_wr_env;

    always_comb begin
        w_wr_audio = i_ctl.valid && i_ctl.cmd == gvs_pkg::CMD_WR_AUDIO
                     && 32'(i_waddr) < AUDIO_DEPTH;
        w_wr_env   = i_ctl.valid && i_ctl.cmd == gvs_pkg::CMD_WR_ENV
                     && 32'(i_waddr) < ENV_DEPTH;
    end

    // audio store: one write, two registered reads
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_wr_audio) begin
                r_audio[AAW'(i_waddr)] <= i_wval;
            end
            o_m0 <= r_audio[i_a0];
            o_m1 <= r_audio[i_a1];
        end
    end

    // envelope store
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_wr_env) begin
                r_envm[EAW'(i_waddr)] <= i_wval;
            end
            o_env <= r_envm[i_eidx];
        end
    end

    // pan gain lookup and pass-through fields
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl.valid <= 1'b0;
        end else if (i_en) begin
            o_ctl   <= i_ctl;
            o_frac  <= i_frac;
            o_ezero <= i_ezero;
            o_gain  <= i_gain;
            o_pg    <= w_cos[i_cidx];
        end
    end

endmodule

@@ hdl/gvs_mac.sv @@
// grain voice arithmetic: linear interpolation, gain products, rounding and saturation
// depends on gvs_pkg; four register stages, one multiplier level in stages 1, 3 and 4

module gvs_mac (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  gvs_pkg::t_ctl      i_ctl,
    input  logic signed [15:0] i_m0,
    input  logic signed [15:0] i_m1,
    input  logic [11:0]        i_frac,
    input  logic signed [15:0] i_env,
    input  logic               i_ezero,
    input  logic [15:0]        i_gain,
    input  logic [15:0]        i_pg,
    output gvs_pkg::t_ctl      o_ctl,
    output logic signed [15:0] o_sample
);

    // stage 1: neighbor weights and gain times pan
    gvs_pkg::t_ctl      r1_ctl;
    logic signed [29:0] r1_p0;
    logic signed [29:0] r1_p1;
    logic signed [15:0] r1_env;
    logic [31:0]        r1_gp;
    logic [12:0]        w_inv;

    assign w_inv = 13'h1000 - {1'b0, i_frac};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r1_ctl <= i_ctl;
            r1_p0  <= 30'(i_m0) * 30'($signed({1'b0, w_inv}));
            r1_p1  <= 30'(i_m1) * 30'($signed({1'b0, i_frac}));
            r1_env <= i_ezero ? 16'sd0 : i_env;
            r1_gp  <= 32'(i_gain) * 32'(i_pg);
        end
    end

    // stage 2: rounded interpolated sample
    gvs_pkg::t_ctl      r2_ctl;
    logic signed [15:0] r2_s;
    logic signed [15:0] r2_env;
    logic [31:0]        r2_gp;
    logic signed [29:0] w_sum;

    assign w_sum = r1_p0 + r1_p1 + 30'sd2048;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r2_ctl <= r1_ctl;
            r2_s   <= w_sum[27:12];
            r2_env <= r1_env;
            r2_gp  <= r1_gp;
        end
    end

    // stage 3: sample times envelope
    gvs_pkg::t_ctl      r3_ctl;
    logic signed [31:0] r3_se;
    logic [31:0]        r3_gp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r3_ctl <= r2_ctl;
            r3_se  <= 32'(r2_s) * 32'(r2_env);
            r3_gp  <= r2_gp;
        end
    end

    // stage 4: full product
    gvs_pkg::t_ctl      r4_ctl;
    logic signed [63:0] r4_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r4_ctl <= r3_ctl;
            r4_acc <= 64'(r3_se) * 64'($signed({1'b0, r3_gp}));
        end
    end

    // round at bit 46 and saturate to 16 bits
    logic signed [63:0] w_rnd;
    logic signed [17:0] w_q;

    always_comb begin
        w_rnd = r4_acc + (64'sd1 <<< 45);
        w_q   = w_rnd[63:46];
        if (w_q > 18'sd32767) begin
            o_sample = 16'sh7fff;
        end else if (w_q < -18'sd32768) begin
            o_sample = 16'sh8000;
        end else begin
            o_sample = w_q[15:0];
        end
    end

    assign o_ctl = r4_ctl;

endmodule

@@ hdl/grain_voice_sample.sv @@
// grain voice sample top level: register file, pipeline and output skid stage
// depends on gvs_pkg, gvs_if, gvs_front, gvs_mem and gvs_mac
// throughput: one item per cycle while the output skid stage holds no item
// the longest part of the pipeline is the 36-stage wrap remainder chain in the front end
// reset clears pipeline valid bits and loads register defaults; memories hold
// unknown data until written and get no clearing pass

module grain_voice_sample #(
    parameter int AUDIO_DEPTH     = gvs_pkg::AUDIO_DEPTH_DEF,
    parameter int ENV_DEPTH       = gvs_pkg::ENV_DEPTH_DEF,
    parameter int COS_TABLE_DEPTH = gvs_pkg::COS_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gvs_in_if.sink     i_in,
    gvs_out_if.source  o_out,
    gvs_cfg_if.sink    i_cfg
);

    localparam int AAW = (AUDIO_DEPTH > 1) ? $clog2(AUDIO_DEPTH) : 1;
    localparam int EAW = (ENV_DEPTH > 1) ? $clog2(ENV_DEPTH) : 1;
    localparam int CIW = $clog2(COS_TABLE_DEPTH + 1);

    // configuration registers
    logic [15:0]        r_start;
    logic [23:0]        r_dur;
    logic signed [15:0] r_rate;
    logic signed [15:0] r_pan;
    logic [16:0]        r_buf_len;
    logic [10:0]        r_env_len;
    logic [31:0]        r_trig;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start   <= '0;
            r_dur     <= 24'd1;
            r_rate    <= 16'sd4096;
            r_pan     <= '0;
            r_buf_len <= 17'd65536;
            r_env_len <= '0;
            r_trig    <= '0;
        end else if (i_cfg.valid) begin
            unique case (gvs_pkg::t_reg_idx'(i_cfg.reg_index))
                gvs_pkg::REG_START:    r_start   <= i_cfg.wdata[15:0];
                gvs_pkg::REG_DURATION: r_dur     <= i_cfg.wdata[23:0];
                gvs_pkg::REG_RATE:     r_rate    <= $signed(i_cfg.wdata[15:0]);
                gvs_pkg::REG_PAN:      r_pan     <= $signed(i_cfg.wdata[15:0]);
                gvs_pkg::REG_BUF_LEN:  r_buf_len <= i_cfg.wdata[16:0];
                gvs_pkg::REG_ENV_LEN:  r_env_len <= i_cfg.wdata[10:0];
                gvs_pkg::REG_TRIGGER:  r_trig    <= i_cfg.wdata;
                default: ;
            endcase
        end
    end

    // range-corrected configuration
    gvs_pkg::t_cfg w_cfg;

    always_comb begin
        w_cfg.start = r_start;
        w_cfg.dur   = (r_dur == 24'd0) ? 24'd1 : r_dur;
        w_cfg.rate  = r_rate;
        w_cfg.pan   = r_pan;
        if (r_buf_len == 17'd0) begin
            w_cfg.n = 17'd1;
        end else if (32'(r_buf_len) > AUDIO_DEPTH) begin
            w_cfg.n = 17'(AUDIO_DEPTH);
        end else begin
            w_cfg.n = r_buf_len;
        end
        w_cfg.len  = (32'(r_env_len) > ENV_DEPTH) ? 11'(ENV_DEPTH) : r_env_len;
        w_cfg.trig = r_trig;
    end

    // pipeline advances unless the skid stage is holding an item
    logic          w_en;
    logic          r_skid_valid;
    gvs_pkg::t_ctl w_in_ctl;

    assign w_en       = !r_skid_valid;
    assign i_in.ready = w_en;

    always_comb begin
        w_in_ctl.valid = i_in.valid && w_en;
        w_in_ctl.cmd   = gvs_pkg::t_cmd'(i_in.command);
    end

    gvs_pkg::t_ctl      f_ctl;
    logic [AAW-1:0]     f_a0;
    logic [AAW-1:0]     f_a1;
    logic [11:0]        f_frac;
    logic [CIW-1:0]     f_cidx;
    logic [15:0]        f_gain;
    logic [15:0]        f_waddr;
    logic signed [15:0] f_wval;
    logic [EAW-1:0]     f_eidx;
    logic               f_ezero;

    gvs_front #(
        .AUDIO_DEPTH     (AUDIO_DEPTH),
        .ENV_DEPTH       (ENV_DEPTH),
        .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_cfg   (w_cfg),
        .i_ctl   (w_in_ctl),
        .i_time  (i_in.sample_time),
        .i_chan  (i_in.channel_position),
        .i_gain  (i_in.envelope_gain),
        .i_waddr (i_in.write_address),
        .i_wval  (i_in.write_value),
        .o_ctl   (f_ctl),
        .o_a0    (f_a0),
        .o_a1    (f_a1),
        .o_frac  (f_frac),
        .o_cidx  (f_cidx),
        .o_gain  (f_gain),
        .o_waddr (f_waddr),
        .o_wval  (f_wval),
        .o_eidx  (f_eidx),
        .o_ezero (f_ezero)
    );

    gvs_pkg::t_ctl      m_ctl;
    logic signed [15:0] m_m0;
    logic signed [15:0] m_m1;
    logic [11:0]        m_frac;
    logic signed [15:0] m_env;
    logic               m_ezero;
    logic [15:0]        m_gain;
    logic [15:0]        m_pg;

    gvs_mem #(
        .AUDIO_DEPTH     (AUDIO_DEPTH),
        .ENV_DEPTH       (ENV_DEPTH),
        .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (f_ctl),
        .i_a0    (f_a0),
        .i_a1    (f_a1),
        .i_frac  (f_frac),
        .i_cidx  (f_cidx),
        .i_gain  (f_gain),
        .i_waddr (f_waddr),
        .i_wval  (f_wval),
        .i_eidx  (f_eidx),
        .i_ezero (f_ezero),
        .o_ctl   (m_ctl),
        .o_m0    (m_m0),
        .o_m1    (m_m1),
        .o_frac  (m_frac),
        .o_env   (m_env),
        .o_ezero (m_ezero),
        .o_gain  (m_gain),
        .o_pg    (m_pg)
    );

    gvs_pkg::t_ctl      a_ctl;
    logic signed [15:0] a_sample;

    gvs_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_ctl    (m_ctl),
        .i_m0     (m_m0),
        .i_m1     (m_m1),
        .i_frac   (m_frac),
        .i_env    (m_env),
        .i_ezero  (m_ezero),
        .i_gain   (m_gain),
        .i_pg     (m_pg),
        .o_ctl    (a_ctl),
        .o_sample (a_sample)
    );

    // output register with one skid entry
    logic               w_push;
    logic               r_out_valid;
    logic signed [15:0] r_out;
    logic signed [15:0] r_skid;

    assign w_push = a_ctl.valid && a_ctl.cmd == gvs_pkg::CMD_PROC;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (o_out.ready) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (w_push) begin
            if (!r_out_valid || o_out.ready) begin
                r_out       <= a_sample;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= a_sample;
                r_skid_valid <= 1'b1;
            end
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_out;

endmodule
